/* hdl/lkv_pkg.sv */
// ----------------------------------------------------------------------------
// lkv_pkg
// Types, codes and constants shared by the LRU key/value cache modules.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int DEF_ENTRIES = 64;
  localparam int CAP_W       = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  localparam logic signed [31:0] MISS_VALUE = -32'sd1;
  localparam logic signed [31:0] PUT_VALUE  = 32'sd0;

  typedef struct packed {
    logic               func;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic scan_rd;
    logic commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic out_free;
  } sts_t;

endpackage

/* hdl/lkv_ctrl.sv */
// ----------------------------------------------------------------------------
// lkv_ctrl
// Sequencer for the cache: clearing pass, scan, commit and result hand-off.
// ----------------------------------------------------------------------------
module lkv_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  lkv_pkg::sts_t   sts,
  output lkv_pkg::cmd_t   cmd,
  output lkv_pkg::state_t state
);

  lkv_pkg::state_t state_r;
  lkv_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lkv_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      lkv_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.idx_last) state_nxt = lkv_pkg::ST_IDLE;
      end
      lkv_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = lkv_pkg::ST_SCAN;
        end
      end
      lkv_pkg::ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.idx_last) state_nxt = lkv_pkg::ST_DRAIN;
      end
      lkv_pkg::ST_DRAIN: begin
        state_nxt = lkv_pkg::ST_DECIDE;
      end
      lkv_pkg::ST_DECIDE: begin
        cmd.commit = 1'b1;
        state_nxt  = lkv_pkg::ST_RESP;
      end
      lkv_pkg::ST_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = lkv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lkv_pkg::ST_CLEAR;
      end
    endcase
  end

  assign state = state_r;

endmodule

/* hdl/lkv_datapath.sv */
// ----------------------------------------------------------------------------
// lkv_datapath
// Entry memories, scan accumulators, recency update and output register.
// ----------------------------------------------------------------------------
module lkv_datapath #(
  parameter int ENTRIES = lkv_pkg::DEF_ENTRIES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lkv_pkg::in_item_t         in_item,
  input  logic                      cfg_wr,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_data,
  input  lkv_pkg::cmd_t             cmd,
  output lkv_pkg::sts_t             sts,
  output logic                      out_valid,
  input  logic                      out_stall,
  output lkv_pkg::out_item_t        out_item
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AW = IW;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int MW = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  logic [AW:0] meta_mem [ENTRIES];
  logic [31:0] key_mem  [ENTRIES];
  logic [31:0] val_mem  [ENTRIES];

  logic [AW:0] meta_q;
  logic [31:0] key_q;
  logic [31:0] val_q;

  logic [IW-1:0] idx_r, idx_nxt;
  logic          chk_vld_r;
  logic [IW-1:0] chk_idx_r;
  lkv_pkg::in_item_t item_r;

  logic          found_r, found_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  logic [AW-1:0] match_age_r, match_age_nxt;
  logic          have_old_r, have_old_nxt;
  logic [IW-1:0] old_idx_r, old_idx_nxt;
  logic [AW-1:0] old_age_r, old_age_nxt;
  logic          have_free_r, have_free_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic [lkv_pkg::CAP_W-1:0] cap_r;

  logic          pend_vld_r, pend_vld_nxt;
  logic          pend_ins_r, pend_ins_nxt;
  logic [IW-1:0] pend_slot_r, pend_slot_nxt;
  logic [AW-1:0] pend_age_r, pend_age_nxt;

  logic               out_full_r, out_full_nxt;
  lkv_pkg::out_item_t out_r;

  logic          m_vld;
  logic [AW-1:0] m_age;
  logic          upd_vld;
  logic [AW-1:0] upd_age;

  logic          meta_we;
  logic [IW-1:0] meta_waddr;
  logic [AW:0]   meta_wdata;
  logic          key_we, val_we;
  logic [IW-1:0] wr_addr;

  logic [MW-1:0] cap_ext, eff_cap;
  logic          at_cap;
  logic          ins_ok, ins_grow;
  logic [IW-1:0] ins_slot;

  assign sts.idx_last = (idx_r == LAST_IDX);
  assign sts.out_free = !out_full_r || !out_stall;

  assign idx_nxt = (cmd.clr_wr || cmd.scan_rd) ? (sts.idx_last ? '0 : idx_r + 1'b1) : idx_r;

  always_ff @(posedge clk) begin
    meta_q <= meta_mem[idx_r];
    key_q  <= key_mem[idx_r];
    val_q  <= val_mem[slot_r];
  end

  assign m_vld = meta_q[AW];
  assign m_age = meta_q[AW-1:0];

  // apply the previous item's recency update on the fly
  always_comb begin
    upd_vld = m_vld;
    upd_age = m_age;
    if (pend_vld_r && chk_idx_r == pend_slot_r) begin
      upd_vld = 1'b1;
      upd_age = '0;
    end else if (pend_vld_r && m_vld && (pend_ins_r || m_age < pend_age_r)) begin
      upd_age = AW'(m_age + 1'b1);
    end
  end

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = chk_idx_r;
    meta_wdata = {upd_vld, upd_age};
    if (cmd.clr_wr) begin
      meta_we    = 1'b1;
      meta_waddr = idx_r;
      meta_wdata = '0;
    end else if (chk_vld_r) begin
      meta_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
  end

  always_comb begin
    found_nxt     = found_r;
    slot_nxt      = slot_r;
    match_age_nxt = match_age_r;
    have_old_nxt  = have_old_r;
    old_idx_nxt   = old_idx_r;
    old_age_nxt   = old_age_r;
    have_free_nxt = have_free_r;
    free_idx_nxt  = free_idx_r;
    if (cmd.load) begin
      found_nxt     = 1'b0;
      have_old_nxt  = 1'b0;
      have_free_nxt = 1'b0;
    end else if (chk_vld_r) begin
      if (upd_vld) begin
        if (!found_r && key_q == item_r.key) begin
          found_nxt     = 1'b1;
          slot_nxt      = chk_idx_r;
          match_age_nxt = upd_age;
        end
        if (!have_old_r || upd_age > old_age_r) begin
          have_old_nxt = 1'b1;
          old_idx_nxt  = chk_idx_r;
          old_age_nxt  = upd_age;
        end
      end else if (!have_free_r) begin
        have_free_nxt = 1'b1;
        free_idx_nxt  = chk_idx_r;
      end
    end
  end

  assign cap_ext = MW'(cap_r);
  assign eff_cap = (cap_r == '0) ? MW'(1) :
                   ((cap_ext > MW'(ENTRIES)) ? MW'(ENTRIES) : cap_ext);
  assign at_cap  = (MW'(count_r) >= eff_cap);

  always_comb begin
    ins_ok   = 1'b0;
    ins_grow = 1'b0;
    ins_slot = old_idx_r;
    priority if (at_cap && have_old_r) begin
      ins_ok = 1'b1;
    end else if (have_free_r) begin
      ins_ok   = 1'b1;
      ins_grow = 1'b1;
      ins_slot = free_idx_r;
    end else if (have_old_r) begin
      ins_ok = 1'b1;
    end
  end

  always_comb begin
    pend_vld_nxt  = pend_vld_r;
    pend_ins_nxt  = pend_ins_r;
    pend_slot_nxt = pend_slot_r;
    pend_age_nxt  = pend_age_r;
    count_nxt     = count_r;
    key_we        = 1'b0;
    val_we        = 1'b0;
    wr_addr       = slot_r;
    if (cmd.commit) begin
      pend_vld_nxt  = 1'b0;
      pend_ins_nxt  = 1'b0;
      pend_slot_nxt = slot_r;
      pend_age_nxt  = match_age_r;
      if (found_r) begin
        pend_vld_nxt = 1'b1;
        val_we       = (item_r.func == lkv_pkg::FUNC_PUT);
      end else if (item_r.func == lkv_pkg::FUNC_PUT && ins_ok) begin
        pend_vld_nxt  = 1'b1;
        pend_ins_nxt  = 1'b1;
        pend_slot_nxt = ins_slot;
        key_we        = 1'b1;
        val_we        = 1'b1;
        wr_addr       = ins_slot;
        if (ins_grow) count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[wr_addr] <= item_r.key;
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[wr_addr] <= item_r.value;
  end

  always_comb begin
    out_full_nxt = out_full_r;
    if (cmd.out_load) begin
      out_full_nxt = 1'b1;
    end else if (!out_stall) begin
      out_full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
    chk_idx_r   <= idx_r;
    slot_r      <= slot_nxt;
    match_age_r <= match_age_nxt;
    old_idx_r   <= old_idx_nxt;
    old_age_r   <= old_age_nxt;
    free_idx_r  <= free_idx_nxt;
    pend_ins_r  <= pend_ins_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_age_r  <= pend_age_nxt;
    if (cmd.out_load) begin
      out_r.hit        <= found_r;
      out_r.read_value <= (item_r.func == lkv_pkg::FUNC_PUT) ? lkv_pkg::PUT_VALUE :
                          (found_r ? $signed(val_q) : lkv_pkg::MISS_VALUE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      chk_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      have_old_r  <= 1'b0;
      have_free_r <= 1'b0;
      count_r     <= '0;
      cap_r       <= lkv_pkg::CAP_RESET;
      pend_vld_r  <= 1'b0;
      out_full_r  <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      chk_vld_r   <= cmd.scan_rd;
      found_r     <= found_nxt;
      have_old_r  <= have_old_nxt;
      have_free_r <= have_free_nxt;
      count_r     <= count_nxt;
      if (cfg_wr) cap_r <= cfg_data;
      pend_vld_r  <= pend_vld_nxt;
      out_full_r  <= out_full_nxt;
    end
  end

  assign out_valid = out_full_r;
  assign out_item  = out_r;

endmodule

/* hdl/lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_item): one get or put per item.
// Result channel (out_valid/out_stall/out_item): one result per item, with
// hit and read_value (stored value on get hit, -1 on get miss, 0 on put).
// Config channel (cfg_valid/cfg_ready/cfg_data): capacity, always ready;
// write it only while the block is idle.
// Each item passes through an accept state, a scan of every entry through
// the single read port of the tag memory, a drain state for the registered
// read, a commit state and a result load. After the result load the block
// returns to idle and can take the next item in the following cycle. The
// recency update of an item is folded into the scan of the next one. Items
// are processed one at a time.
// After reset a clearing pass over every entry empties the store; input is
// stalled during it while config writes are still taken.
// When the receiver stalls, the result is held in the output register; the
// next item is still taken and processed, and its result waits until the
// held one has been taken.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int ENTRIES = lkv_pkg::DEF_ENTRIES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  lkv_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output lkv_pkg::out_item_t        out_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_data
);

  lkv_pkg::cmd_t   cmd;
  lkv_pkg::sts_t   sts;
  lkv_pkg::state_t state;

  assign cfg_ready = 1'b1;

  lkv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  lkv_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  a_result_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state == lkv_pkg::ST_RESP))
    else $error("result appeared without a commit");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state == lkv_pkg::ST_SCAN))
    else $error("accepted item did not start a scan");

  a_scan_covers_all: assert property (@(posedge clk) disable iff (!rst_n)
    (state == lkv_pkg::ST_SCAN && !sts.idx_last) |=> (state == lkv_pkg::ST_SCAN))
    else $error("scan ended before the last entry");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state == lkv_pkg::ST_CLEAR) |-> (in_stall && !out_valid))
    else $error("activity during clearing pass");

endmodule
